// ----- hdl/mer_pkg.sv -----
`timescale 1ns / 1ps

package mer_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int RAD_W   = 11;
    localparam int OFF_W   = 12;
    localparam int SQ_W    = 2 * RAD_W;
    localparam int PXY_W   = SQ_W + OFF_W + 2;
    localparam int MUL_W   = 26;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int DEC_W   = PROD_W;
    localparam int ADDR_W  = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Y = 2'd3;

    localparam logic [ADDR_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [ADDR_W-1:0] ST_INIT0 = 4'd1;
    localparam logic [ADDR_W-1:0] ST_INIT1 = 4'd2;
    localparam logic [ADDR_W-1:0] ST_INIT2 = 4'd3;
    localparam logic [ADDR_W-1:0] ST_INIT3 = 4'd4;
    localparam logic [ADDR_W-1:0] ST_INIT4 = 4'd5;
    localparam logic [ADDR_W-1:0] ST_INIT5 = 4'd6;
    localparam logic [ADDR_W-1:0] ST_SW0   = 4'd7;
    localparam logic [ADDR_W-1:0] ST_SW1   = 4'd8;
    localparam logic [ADDR_W-1:0] ST_SW2   = 4'd9;
    localparam logic [ADDR_W-1:0] ST_SW3   = 4'd10;
    localparam logic [ADDR_W-1:0] ST_SW4   = 4'd11;
    localparam logic [ADDR_W-1:0] ST_SW5   = 4'd12;
    localparam logic [ADDR_W-1:0] ST_MOVE  = 4'd13;
    localparam logic [ADDR_W-1:0] ST_EMIT  = 4'd14;

    typedef enum logic [1:0] {
        J_NEXT,
        J_GOTO,
        J_DISPATCH
    } t_jmp;

    typedef enum logic [2:0] {
        M_RX,
        M_RY,
        M_A,
        M_B,
        M_H,
        M_K,
        M_PROD
    } t_msel;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_LD_A,
        OP_LD_B,
        OP_INIT_DEC,
        OP_ACC_LD,
        OP_ACC_ADD4,
        OP_SW_DEC,
        OP_MOVE,
        OP_DEC_UPD
    } t_dop;

    typedef struct packed {
        logic              accept;
        logic              emit;
        logic              mul_en;
        t_msel             mul_a;
        t_msel             mul_b;
        t_dop              op;
        t_jmp              jmp;
        logic [ADDR_W-1:0] target;
    } t_ctl;

    typedef struct packed {
        logic started;
        logic in_r2;
        logic px_le_py;
        logic out_busy;
    } t_stat;

    localparam t_ctl CTL_NOP = '{
        accept: 1'b0,
        emit:   1'b0,
        mul_en: 1'b0,
        mul_a:  M_RX,
        mul_b:  M_RX,
        op:     OP_NONE,
        jmp:    J_NEXT,
        target: ST_IDLE
    };

    function automatic t_ctl ucode(input logic [ADDR_W-1:0] addr);
        t_ctl c;
        c = CTL_NOP;
        unique case (addr)
            ST_IDLE: begin
                c.accept = 1'b1;
                c.jmp    = J_DISPATCH;
            end
            ST_INIT0: begin
                c.op = OP_LATCH;
            end
            ST_INIT1: begin
                c.mul_en = 1'b1;
                c.mul_a  = M_RY;
                c.mul_b  = M_RY;
            end
            ST_INIT2: begin
                c.op     = OP_LD_A;
                c.mul_en = 1'b1;
                c.mul_a  = M_RX;
                c.mul_b  = M_RX;
            end
            ST_INIT3: begin
                c.op = OP_LD_B;
            end
            ST_INIT4: begin
                c.mul_en = 1'b1;
                c.mul_a  = M_B;
                c.mul_b  = M_RY;
            end
            ST_INIT5: begin
                c.op     = OP_INIT_DEC;
                c.jmp    = J_GOTO;
                c.target = ST_MOVE;
            end
            ST_SW0: begin
                c.mul_en = 1'b1;
                c.mul_a  = M_H;
                c.mul_b  = M_H;
            end
            ST_SW1: begin
                c.mul_en = 1'b1;
                c.mul_a  = M_A;
                c.mul_b  = M_PROD;
            end
            ST_SW2: begin
                c.op     = OP_ACC_LD;
                c.mul_en = 1'b1;
                c.mul_a  = M_K;
                c.mul_b  = M_K;
            end
            ST_SW3: begin
                c.mul_en = 1'b1;
                c.mul_a  = M_B;
                c.mul_b  = M_PROD;
            end
            ST_SW4: begin
                c.op     = OP_ACC_ADD4;
                c.mul_en = 1'b1;
                c.mul_a  = M_A;
                c.mul_b  = M_B;
            end
            ST_SW5: begin
                c.op     = OP_SW_DEC;
                c.jmp    = J_GOTO;
                c.target = ST_MOVE;
            end
            ST_MOVE: begin
                c.op = OP_MOVE;
            end
            ST_EMIT: begin
                c.op     = OP_DEC_UPD;
                c.emit   = 1'b1;
                c.jmp    = J_GOTO;
                c.target = ST_IDLE;
            end
            default: begin
                c.jmp    = J_GOTO;
                c.target = ST_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/midpoint_ellipse_rasterizer.sv -----
`timescale 1ns / 1ps

// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata[0] restart
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata x_right,x_left,y_lower,y_upper; tlast
// cfg       in   i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// A step runs dispatch, move, then decision update with result load.
// Starting a walk adds the INIT0-INIT5 steps, the one-time region switch the SW0-SW5 steps;
// both use the shared 26x26 multiplier that the microprogram runs through.
// Reset clears the step counter and walk flags; the first transfer starts a walk.
// A full result register stalls the sequencer only at its result-load step.

module midpoint_ellipse_rasterizer #(
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [0] restart
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // x_right, x_left, y_lower, y_upper, each COORD_BITS+2 bits, from bit 0 up
    output logic [((4*(COORD_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mer_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [((COORD_BITS > mer_pkg::RAD_W) ? COORD_BITS : mer_pkg::RAD_W)-1:0]
                                                i_cfg_data
);

    localparam int OW   = COORD_BITS + 2;
    localparam int TD_W = ((4 * OW + 7) / 8) * 8;

    mer_pkg::t_ctl  ctl;
    mer_pkg::t_stat stat;
    logic           fire;
    logic [OW-1:0]  x_right, x_left, y_lower, y_upper;

    mer_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_restart  (s_axis_tdata[0]),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_ctl      (ctl),
        .o_fire     (fire)
    );

    mer_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_fire      (fire),
        .o_stat      (stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_x_right   (x_right),
        .o_x_left    (x_left),
        .o_y_lower   (y_lower),
        .o_y_upper   (y_upper),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = TD_W'({y_upper, y_lower, x_left, x_right});
    assign o_cfg_ready  = 1'b1;

endmodule

// ----- hdl/mer_sequencer.sv -----
`timescale 1ns / 1ps

module mer_sequencer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_restart,
    input  mer_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output mer_pkg::t_ctl  o_ctl,
    output logic           o_fire
);

    logic [mer_pkg::ADDR_W-1:0] r_step;
    logic [mer_pkg::ADDR_W-1:0] n_step;
    mer_pkg::t_ctl              ctl;
    logic                       fire;

    always_comb begin
        ctl = mer_pkg::ucode(r_step);
        priority if (ctl.accept) begin
            fire = i_in_valid;
        end else if (ctl.emit) begin
            fire = !i_stat.out_busy;
        end else begin
            fire = 1'b1;
        end
    end

    always_comb begin
        n_step = r_step;
        if (fire) begin
            unique case (ctl.jmp)
                mer_pkg::J_NEXT: begin
                    n_step = r_step + 1'b1;
                end
                mer_pkg::J_GOTO: begin
                    n_step = ctl.target;
                end
                mer_pkg::J_DISPATCH: begin
                    priority if (i_restart || !i_stat.started) begin
                        n_step = mer_pkg::ST_INIT0;
                    end else if (i_stat.in_r2 || i_stat.px_le_py) begin
                        n_step = mer_pkg::ST_MOVE;
                    end else begin
                        n_step = mer_pkg::ST_SW0;
                    end
                end
                default: begin
                    n_step = mer_pkg::ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= mer_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctl      = ctl;
    assign o_fire     = fire;
    assign o_in_ready = ctl.accept;

endmodule

// ----- hdl/mer_datapath.sv -----
`timescale 1ns / 1ps

module mer_datapath #(
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mer_pkg::t_ctl                       i_ctl,
    input  logic                                i_fire,
    output mer_pkg::t_stat                      o_stat,
    input  logic                                i_cfg_valid,
    input  logic [mer_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [((COORD_BITS > mer_pkg::RAD_W) ? COORD_BITS : mer_pkg::RAD_W)-1:0]
                                                i_cfg_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [COORD_BITS+1:0]               o_x_right,
    output logic [COORD_BITS+1:0]               o_x_left,
    output logic [COORD_BITS+1:0]               o_y_lower,
    output logic [COORD_BITS+1:0]               o_y_upper,
    output logic                                o_last
);

    localparam int OW    = COORD_BITS + 2;
    localparam int DEC_W = mer_pkg::DEC_W;
    localparam int PXY_W = mer_pkg::PXY_W;
    localparam int MUL_W = mer_pkg::MUL_W;

    logic [COORD_BITS-1:0]       r_cx, r_cy;
    logic [mer_pkg::RAD_W-1:0]   r_rx_cfg, r_ry_cfg;
    logic [mer_pkg::RAD_W-1:0]   r_rx, r_ry;
    logic [mer_pkg::SQ_W-1:0]    r_a, r_b;
    logic [mer_pkg::OFF_W-1:0]   r_x;
    logic [mer_pkg::RAD_W-1:0]   r_y;
    logic [PXY_W-1:0]            r_px, r_py;
    logic signed [DEC_W-1:0]     r_dec, r_acc;
    logic [mer_pkg::PROD_W-1:0]  r_prod;
    logic                        r_r2, r_diag, r_started;
    logic                        r_ovalid;
    logic [OW-1:0]               r_xr, r_xl, r_yl, r_yu;
    logic                        r_last;

    logic [MUL_W-1:0]            op_a, op_b;
    logic signed [DEC_W-1:0]     s_a, s_b, s_px, s_py, s_prod, s_b4;
    logic                        diag, step_x, step_y;
    logic [PXY_W-1:0]            a2, b2;

    function automatic logic [MUL_W-1:0] msel(input mer_pkg::t_msel s);
        logic [MUL_W-1:0] v;
        unique case (s)
            mer_pkg::M_RX:   v = MUL_W'(r_rx);
            mer_pkg::M_RY:   v = MUL_W'(r_ry);
            mer_pkg::M_A:    v = MUL_W'(r_a);
            mer_pkg::M_B:    v = MUL_W'(r_b);
            mer_pkg::M_H:    v = MUL_W'({r_x, 1'b1});
            mer_pkg::M_K:    v = MUL_W'(r_y - 1'b1);
            mer_pkg::M_PROD: v = r_prod[MUL_W-1:0];
            default:         v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        op_a   = msel(i_ctl.mul_a);
        op_b   = msel(i_ctl.mul_b);
        s_a    = DEC_W'(r_a);
        s_b    = DEC_W'(r_b);
        s_px   = DEC_W'(r_px);
        s_py   = DEC_W'(r_py);
        s_prod = DEC_W'(r_prod);
        s_b4   = DEC_W'(r_b >> 2);
        a2     = PXY_W'({r_a, 1'b0});
        b2     = PXY_W'({r_b, 1'b0});
        if (r_r2) begin
            diag   = r_dec[DEC_W-1] || (r_dec == '0);
            step_x = diag;
            step_y = 1'b1;
        end else begin
            diag   = !r_dec[DEC_W-1];
            step_x = 1'b1;
            step_y = diag;
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_rx_cfg <= mer_pkg::RAD_W'(1);
            r_ry_cfg <= mer_pkg::RAD_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mer_pkg::CFG_CENTER_X: r_cx     <= i_cfg_data[COORD_BITS-1:0];
                mer_pkg::CFG_CENTER_Y: r_cy     <= i_cfg_data[COORD_BITS-1:0];
                mer_pkg::CFG_RADIUS_X: r_rx_cfg <= i_cfg_data[mer_pkg::RAD_W-1:0];
                mer_pkg::CFG_RADIUS_Y: r_ry_cfg <= i_cfg_data[mer_pkg::RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_r2      <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_fire && i_ctl.op == mer_pkg::OP_LATCH) begin
                r_started <= 1'b1;
                r_r2      <= 1'b0;
            end
            if (i_fire && i_ctl.op == mer_pkg::OP_SW_DEC) begin
                r_r2 <= 1'b1;
            end
            if (i_fire && i_ctl.emit && r_y == '0) begin
                r_started <= 1'b0;
            end
            if (i_fire && i_ctl.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_fire && i_ctl.mul_en) begin
            r_prod <= mer_pkg::PROD_W'(op_a * op_b);
        end
        if (i_fire) begin
            unique case (i_ctl.op)
                mer_pkg::OP_NONE: begin
                end
                mer_pkg::OP_LATCH: begin
                    r_rx <= (r_rx_cfg == '0) ? mer_pkg::RAD_W'(1) : r_rx_cfg;
                    r_ry <= (r_ry_cfg == '0) ? mer_pkg::RAD_W'(1) : r_ry_cfg;
                    r_x  <= '0;
                    r_y  <= (r_ry_cfg == '0) ? mer_pkg::RAD_W'(1) : r_ry_cfg;
                end
                mer_pkg::OP_LD_A: begin
                    r_a <= r_prod[mer_pkg::SQ_W-1:0];
                end
                mer_pkg::OP_LD_B: begin
                    r_b <= r_prod[mer_pkg::SQ_W-1:0];
                end
                mer_pkg::OP_INIT_DEC: begin
                    r_dec <= s_a - s_prod + s_b4;
                    r_px  <= '0;
                    r_py  <= PXY_W'({r_prod, 1'b0});
                end
                mer_pkg::OP_ACC_LD: begin
                    r_acc <= s_prod;
                end
                mer_pkg::OP_ACC_ADD4: begin
                    r_acc <= r_acc + (s_prod <<< 2);
                end
                mer_pkg::OP_SW_DEC: begin
                    r_dec <= r_acc - (s_prod <<< 2);
                end
                mer_pkg::OP_MOVE: begin
                    r_diag <= diag;
                    if (step_x) begin
                        r_x  <= r_x + 1'b1;
                        r_px <= r_px + a2;
                    end
                    if (step_y) begin
                        r_y  <= r_y - 1'b1;
                        r_py <= r_py - b2;
                    end
                end
                mer_pkg::OP_DEC_UPD: begin
                    if (r_r2) begin
                        r_dec <= r_dec + (((r_diag ? s_px : '0) - s_py + s_b) <<< 2);
                    end else begin
                        r_dec <= r_dec + s_px + s_a - (r_diag ? s_py : '0);
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_fire && i_ctl.emit) begin
            r_xr   <= OW'(r_cx) + OW'(r_x);
            r_xl   <= OW'(r_cx) - OW'(r_x);
            r_yl   <= OW'(r_cy) + OW'(r_y);
            r_yu   <= OW'(r_cy) - OW'(r_y);
            r_last <= (r_y == '0);
        end
    end

    assign o_stat.started  = r_started;
    assign o_stat.in_r2    = r_r2;
    assign o_stat.px_le_py = (r_px <= r_py);
    assign o_stat.out_busy = r_ovalid && !i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_x_right   = r_xr;
    assign o_x_left    = r_xl;
    assign o_y_lower   = r_yl;
    assign o_y_upper   = r_yu;
    assign o_last      = r_last;

endmodule

// ----- bench/ellipse_point_checker.sv -----
`timescale 1ns / 1ps

module ellipse_point_checker #(
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    input  logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,
    input  logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic [((4*(COORD_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
    input  logic                                  m_axis_tlast,
    input  logic                                  i_cfg_valid,
    input  logic                                  o_cfg_ready,
    input  logic [mer_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [((COORD_BITS > mer_pkg::RAD_W) ? COORD_BITS : mer_pkg::RAD_W)-1:0]
                                                  i_cfg_data,
    output int                                    o_fail_count,
    output int                                    o_pending
);

    localparam int OUT_W = COORD_BITS + 2;

    typedef struct packed {
        logic [OUT_W-1:0] x_right;
        logic [OUT_W-1:0] x_left;
        logic [OUT_W-1:0] y_lower;
        logic [OUT_W-1:0] y_upper;
        logic             last;
    } t_point;

    logic [COORD_BITS-1:0]     center_x;
    logic [COORD_BITS-1:0]     center_y;
    logic [mer_pkg::RAD_W-1:0] radius_x;
    logic [mer_pkg::RAD_W-1:0] radius_y;

    longint walk_rx, walk_ry, off_x, off_y, decision;
    bit     region_two, walking;

    t_point expected_points[$];
    int     fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    function automatic logic [OUT_W-1:0] wrap_coord(input longint v);
        return v[OUT_W-1:0];
    endfunction

    function automatic void region_two_step(input longint sq_ry, input longint sq_rx);
        if (decision <= 0) begin
            off_x++;
            off_y--;
            decision += 4 * (2 * sq_ry * off_x - 2 * sq_rx * off_y + sq_rx);
        end else begin
            off_y--;
            decision += 4 * (sq_rx - 2 * sq_rx * off_y);
        end
    endfunction

    function automatic t_point advance_walk(input bit restart);
        longint sq_ry, sq_rx, h, k, cx, cy;
        t_point p;
        if (restart || !walking) begin
            walk_rx    = (radius_x == 0) ? 1 : longint'(radius_x);
            walk_ry    = (radius_y == 0) ? 1 : longint'(radius_y);
            off_x      = 0;
            off_y      = walk_ry;
            region_two = 1'b0;
            decision   = walk_ry * walk_ry - walk_rx * walk_rx * walk_ry
                         + (walk_rx * walk_rx) / 4;
            walking    = 1'b1;
        end
        sq_ry = walk_ry * walk_ry;
        sq_rx = walk_rx * walk_rx;
        if (!region_two) begin
            if (2 * sq_ry * off_x <= 2 * sq_rx * off_y) begin
                off_x++;
                if (decision < 0) begin
                    decision += 2 * sq_ry * off_x + sq_ry;
                end else begin
                    off_y--;
                    decision += 2 * sq_ry * off_x - 2 * sq_rx * off_y + sq_ry;
                end
            end else begin
                // decision kept as 4x the region-two value
                h          = 2 * off_x + 1;
                k          = off_y - 1;
                region_two = 1'b1;
                decision   = sq_ry * h * h + 4 * sq_rx * k * k - 4 * sq_rx * sq_ry;
                region_two_step(sq_ry, sq_rx);
            end
        end else begin
            region_two_step(sq_ry, sq_rx);
        end
        cx        = longint'(center_x);
        cy        = longint'(center_y);
        p.x_right = wrap_coord(cx + off_x);
        p.x_left  = wrap_coord(cx - off_x);
        p.y_lower = wrap_coord(cy + off_y);
        p.y_upper = wrap_coord(cy - off_y);
        p.last    = (off_y <= 0);
        if (p.last)
            walking = 1'b0;
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_point got, want;
        if (!i_rst_n) begin
            center_x   = '0;
            center_y   = '0;
            radius_x   = mer_pkg::RAD_W'(1);
            radius_y   = mer_pkg::RAD_W'(1);
            walk_rx    = 1;
            walk_ry    = 1;
            off_x      = 0;
            off_y      = 0;
            decision   = 0;
            region_two = 1'b0;
            walking    = 1'b0;
            expected_points.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    mer_pkg::CFG_CENTER_X: center_x = i_cfg_data[COORD_BITS-1:0];
                    mer_pkg::CFG_CENTER_Y: center_y = i_cfg_data[COORD_BITS-1:0];
                    mer_pkg::CFG_RADIUS_X: radius_x = i_cfg_data[mer_pkg::RAD_W-1:0];
                    mer_pkg::CFG_RADIUS_Y: radius_y = i_cfg_data[mer_pkg::RAD_W-1:0];
                    default: ;
                endcase
            end
            // result side first: a point can never leave in the cycle its request arrives
            if (m_axis_tvalid && m_axis_tready) begin
                got.x_right = m_axis_tdata[OUT_W-1:0];
                got.x_left  = m_axis_tdata[2*OUT_W-1:OUT_W];
                got.y_lower = m_axis_tdata[3*OUT_W-1:2*OUT_W];
                got.y_upper = m_axis_tdata[4*OUT_W-1:3*OUT_W];
                got.last    = m_axis_tlast;
                if (expected_points.size() == 0) begin
                    report_mismatch($sformatf("unexpected point transfer, tdata 0x%0h",
                                              m_axis_tdata));
                end else begin
                    want = expected_points.pop_front();
                    compare_field("x_right", longint'(got.x_right), longint'(want.x_right));
                    compare_field("x_left",  longint'(got.x_left),  longint'(want.x_left));
                    compare_field("y_lower", longint'(got.y_lower), longint'(want.y_lower));
                    compare_field("y_upper", longint'(got.y_upper), longint'(want.y_upper));
                    compare_field("tlast",   longint'(got.last),    longint'(want.last));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_points.push_back(advance_walk(s_axis_tdata[0]));
        end
        o_pending = expected_points.size();
    end

endmodule

// ----- bench/midpoint_ellipse_rasterizer_tb.sv -----
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_tb;

    localparam int COORD_BITS = mer_pkg::COORD_BITS_DEF;
    localparam int DATA_W     = ((4 * (COORD_BITS + 2) + 7) / 8) * 8;
    localparam int CFG_W      = (COORD_BITS > mer_pkg::RAD_W) ? COORD_BITS : mer_pkg::RAD_W;
    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1550;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [DATA_W-1:0]             m_axis_tdata;
    logic                          m_axis_tlast;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [mer_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]              i_cfg_data;

    int fail_count;
    int pending;
    bit no_idle;
    int items_sent;

    midpoint_ellipse_rasterizer #(
        .COORD_BITS(COORD_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    ellipse_point_checker #(
        .COORD_BITS(COORD_BITS)
    ) u_point_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_item(input bit restart);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, restart};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    task automatic run_items(input int count, input int restart_pct);
        repeat (count) send_item($urandom_range(0, 99) < restart_pct);
    endtask

    // leaves valid high so back-to-back writes need no extra step
    task automatic write_reg(input logic [mer_pkg::CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (16) @(posedge i_clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_center();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return CFG_W'((1 << COORD_BITS) - 1);
        return CFG_W'($urandom_range(0, (1 << COORD_BITS) - 1));
    endfunction

    function automatic logic [CFG_W-1:0] pick_radius();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 13)
            return CFG_W'($urandom_range(1, 24));
        else if (sel < 16)
            return CFG_W'($urandom_range(25, 300));
        else if (sel == 16)
            return CFG_W'((1 << mer_pkg::RAD_W) - 1);
        else if (sel == 17)
            return CFG_W'(1);
        else if (sel == 18)
            return '0;
        return CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
    endfunction

    // result side; long hold-offs let the block back up into its input
    initial begin
        int gap;
        int got;
        got = 0;
        m_axis_tready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (got == 250 || got == 900)
                gap = 120;
            else if (no_idle)
                gap = 0;
            else
                gap = $urandom_range(0, 3);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            got++;
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        wait (i_rst_n);
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        int phase_len;
        int restart_pct;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= mer_pkg::CFG_CENTER_X;
        i_cfg_data    <= '0;
        no_idle        = 1'b0;
        i_rst_n       <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unit ellipse at the origin from reset values; negative x_left wraps
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        wait_drained();

        // largest center and radii
        write_reg(mer_pkg::CFG_CENTER_X, CFG_W'((1 << COORD_BITS) - 1));
        write_reg(mer_pkg::CFG_CENTER_Y, CFG_W'((1 << COORD_BITS) - 1));
        write_reg(mer_pkg::CFG_RADIUS_X, CFG_W'((1 << mer_pkg::RAD_W) - 1));
        write_reg(mer_pkg::CFG_RADIUS_Y, CFG_W'((1 << mer_pkg::RAD_W) - 1));
        i_cfg_valid <= 1'b0;
        repeat (3) send_item(1'b0);
        send_item(1'b1);
        repeat (2) send_item(1'b0);
        wait_drained();

        // zero radius acts as one, radius data above bit 10 dropped; early region switch
        write_reg(mer_pkg::CFG_CENTER_X, '0);
        write_reg(mer_pkg::CFG_CENTER_Y, '0);
        write_reg(mer_pkg::CFG_RADIUS_X, '0);
        write_reg(mer_pkg::CFG_RADIUS_Y, 12'h805);
        i_cfg_valid <= 1'b0;
        repeat (3) send_item(1'b0);
        wait_drained();

        // mid-walk writes: radii wait for the next start, center applies at once
        write_reg(mer_pkg::CFG_RADIUS_X, CFG_W'(7));
        write_reg(mer_pkg::CFG_RADIUS_Y, CFG_W'(3));
        write_reg(mer_pkg::CFG_CENTER_X, CFG_W'(100));
        i_cfg_valid <= 1'b0;
        repeat (5) send_item(1'b0);
        repeat (2) send_item(1'b1);
        send_item(1'b0);
        wait_drained();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent == 0 || $urandom_range(0, 1))
                write_reg(mer_pkg::CFG_CENTER_X, pick_center());
            if (items_sent == 0 || $urandom_range(0, 1))
                write_reg(mer_pkg::CFG_CENTER_Y, pick_center());
            if (items_sent == 0 || $urandom_range(0, 1))
                write_reg(mer_pkg::CFG_RADIUS_X, pick_radius());
            if (items_sent == 0 || $urandom_range(0, 1))
                write_reg(mer_pkg::CFG_RADIUS_Y, pick_radius());
            i_cfg_valid <= 1'b0;
            no_idle     = ($urandom_range(0, 3) == 0);
            phase_len   = $urandom_range(20, 80);
            restart_pct = ($urandom_range(0, 4) == 0) ? 30 : 2;
            run_items(phase_len, restart_pct);
            items_sent += phase_len;
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
